/* sv/csmg_pkg.sv */
// ----------------------------------------------------------------------------
// csmg_pkg
// Shared constants and types of the color Sobel max-channel gradient block.
// ----------------------------------------------------------------------------
package csmg_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int GRAD_W     = 11;
  localparam int MSQ_W      = 21;
  localparam int FRAC_BITS  = 4;
  localparam int MAG_W      = 15;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int REM_W      = MAG_W + 4;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  // one input that releases results: its window and position
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;  // [row slot][col slot], slot 2 newest
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       last_col;
    logic                       last_row;
  } job_t;

endpackage

/* sv/csmg_ram.sv */
// ----------------------------------------------------------------------------
// csmg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module csmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/csmg_front.sv */
// ----------------------------------------------------------------------------
// csmg_front
// Pixel intake: size registers, raster counters, line stores and the 3x3
// window. Inputs that complete a neighbourhood are pushed as jobs.
// ----------------------------------------------------------------------------
module csmg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_index,
  input  logic [csmg_pkg::CFG_H_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csmg_pkg::PIX_W-1:0]    in_pix,
  output logic                          job_valid,
  input  logic                          job_ready,
  output csmg_pkg::job_t                job
);

  logic [csmg_pkg::CFG_W_W-1:0] width_r;
  logic [csmg_pkg::CFG_H_W-1:0] height_r;
  logic [csmg_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [csmg_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [csmg_pkg::CFG_W_W-1:0] w_eff;
  logic [csmg_pkg::CFG_H_W-1:0] h_eff;
  logic [csmg_pkg::COL_W-1:0]   c_cur;
  logic [csmg_pkg::ROW_W-1:0]   r_cur;
  logic                         restart;
  logic                         accept;

  logic                         s2_valid_r;
  logic [csmg_pkg::PIX_W-1:0]   s2_pix_r;
  logic [csmg_pkg::COL_W-1:0]   s2_col_r;
  logic [csmg_pkg::ROW_W-1:0]   s2_row_r;
  logic                         s2_emit_r;
  logic                         s2_lc_r;
  logic                         s2_lr_r;
  logic                         s2_fire;

  logic [csmg_pkg::PIX_W-1:0]   older_rd, newer_rd;
  logic [2:0][2:0][csmg_pkg::PIX_W-1:0] win_r, win_nxt;

  always_comb begin
    w_eff = width_r;
    if (width_r < csmg_pkg::CFG_W_W'(2)) w_eff = csmg_pkg::CFG_W_W'(2);
    if (width_r > csmg_pkg::CFG_W_W'(csmg_pkg::MAX_WIDTH))
      w_eff = csmg_pkg::CFG_W_W'(csmg_pkg::MAX_WIDTH);
    h_eff = height_r;
    if (height_r < csmg_pkg::CFG_H_W'(2)) h_eff = csmg_pkg::CFG_H_W'(2);
    if (height_r > csmg_pkg::CFG_H_W'(csmg_pkg::MAX_HEIGHT))
      h_eff = csmg_pkg::CFG_H_W'(csmg_pkg::MAX_HEIGHT);
  end

  // size shrunk under the counters: restart the frame
  assign restart = ({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff);
  assign c_cur   = restart ? '0 : col_r;
  assign r_cur   = restart ? '0 : row_r;

  assign s2_fire  = s2_valid_r && (!s2_emit_r || job_ready);
  assign in_ready = !s2_valid_r || s2_fire;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt = c_cur + 1'b1;
    row_nxt = r_cur;
    if ({1'b0, c_cur} + 12'd1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = r_cur + 1'b1;
      if ({1'b0, r_cur} + 13'd1 >= h_eff) row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= csmg_pkg::CFG_W_W'(640);
      height_r <= csmg_pkg::CFG_H_W'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        csmg_pkg::REG_WIDTH:  width_r  <= cfg_wdata[csmg_pkg::CFG_W_W-1:0];
        csmg_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        s2_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_pix_r  <= in_pix;
      s2_col_r  <= c_cur;
      s2_row_r  <= r_cur;
      s2_emit_r <= (r_cur != '0) && (c_cur != '0);
      s2_lc_r   <= ({1'b0, c_cur} == w_eff - 1'b1);
      s2_lr_r   <= ({1'b0, r_cur} == h_eff - 1'b1);
    end
  end

  csmg_ram #(.WIDTH(csmg_pkg::PIX_W), .DEPTH(csmg_pkg::MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (s2_fire),
    .wr_addr (s2_col_r),
    .wr_data (newer_rd),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (older_rd)
  );

  csmg_ram #(.WIDTH(csmg_pkg::PIX_W), .DEPTH(csmg_pkg::MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (s2_fire),
    .wr_addr (s2_col_r),
    .wr_data (s2_pix_r),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (newer_rd)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = older_rd;
    win_nxt[1][2] = newer_rd;
    win_nxt[2][2] = s2_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s2_fire) begin
      win_r <= win_nxt;
    end
  end

  assign job_valid    = s2_valid_r && s2_emit_r;
  assign job.win      = win_nxt;
  assign job.row      = s2_row_r;
  assign job.col      = s2_col_r;
  assign job.last_col = s2_lc_r;
  assign job.last_row = s2_lr_r;

endmodule

/* sv/csmg_queue.sv */
// ----------------------------------------------------------------------------
// csmg_queue
// Two-entry job queue between intake and gradient engine.
// ----------------------------------------------------------------------------
module csmg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  csmg_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csmg_pkg::job_t pop_data
);

  csmg_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wp_r != rp_r)) else $error("queue pointers out of step");
`endif

endmodule

/* sv/csmg_back.sv */
// ----------------------------------------------------------------------------
// csmg_back
// Gradient engine: per job, walks the 1..4 released pixels, forms Sobel
// responses on all three channels, picks the strongest and takes the root.
// ----------------------------------------------------------------------------
module csmg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  csmg_pkg::job_t                 job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csmg_pkg::COL_W-1:0]     out_col,
  output logic [csmg_pkg::ROW_W-1:0]     out_row,
  output logic signed [csmg_pkg::GRAD_W-1:0] out_gx,
  output logic signed [csmg_pkg::GRAD_W-1:0] out_gy,
  output logic [csmg_pkg::MSQ_W-1:0]     out_msq,
  output logic [csmg_pkg::MAG_W-1:0]     out_mag,
  output logic [1:0]                     out_channel,
  output logic                           out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GRAD = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_SEL  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]     state_r;
  csmg_pkg::job_t job_r;
  logic           dr_r, dc_r;
  logic           has_next;
  logic           dr_nxt, dc_nxt;

  logic [csmg_pkg::ROW_W-1:0] rr;
  logic [csmg_pkg::COL_W-1:0] cc;
  logic [1:0] rs [3];
  logic [1:0] cs [3];
  logic signed [csmg_pkg::GRAD_W-1:0] gx_c [3];
  logic signed [csmg_pkg::GRAD_W-1:0] gy_c [3];
  logic signed [csmg_pkg::GRAD_W-1:0] gx_r [3];
  logic signed [csmg_pkg::GRAD_W-1:0] gy_r [3];
  logic [csmg_pkg::MSQ_W-1:0] msq_r [3];
  logic signed [2*csmg_pkg::GRAD_W-1:0] sqx [3];
  logic signed [2*csmg_pkg::GRAD_W-1:0] sqy [3];
  logic [1:0] best;

  logic [csmg_pkg::RAD_W-1:0] rad_r;
  logic [csmg_pkg::REM_W-1:0] rem_r, rem_sh, trial;
  logic [csmg_pkg::MAG_W-1:0] root_r;
  logic [3:0]                 cnt_r;

  assign rr = job_r.row - csmg_pkg::ROW_W'(dr_r);
  assign cc = job_r.col - csmg_pkg::COL_W'(dc_r);

  // window slots, reflect-101 folded in
  always_comb begin
    rs[0] = dr_r ? ((rr == '0) ? 2'd2 : 2'd0) : 2'd1;
    rs[1] = dr_r ? 2'd1 : 2'd2;
    rs[2] = dr_r ? 2'd2 : 2'd1;
    cs[0] = dc_r ? ((cc == '0) ? 2'd2 : 2'd0) : 2'd1;
    cs[1] = dc_r ? 2'd1 : 2'd2;
    cs[2] = dc_r ? 2'd2 : 2'd1;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [csmg_pkg::GRAD_W-1:0] p [3][3];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] = $signed({3'b000, job_r.win[rs[i]][cs[j]][8*k +: 8]});
      gx_c[k] = csmg_pkg::GRAD_W'((p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) +
                                  (p[2][2] - p[2][0]));
      gy_c[k] = csmg_pkg::GRAD_W'((p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) +
                                  (p[2][2] - p[0][2]));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqx[k] = gx_r[k] * gx_r[k];
      sqy[k] = gy_r[k] * gy_r[k];
    end
  end

  always_comb begin
    best = csmg_pkg::CH_BLUE;
    if (msq_r[1] > msq_r[0]) best = csmg_pkg::CH_GREEN;
    if (msq_r[2] > msq_r[best]) best = csmg_pkg::CH_RED;
  end

  // release order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  always_comb begin
    has_next = 1'b0;
    dr_nxt   = dr_r;
    dc_nxt   = dc_r;
    case ({dr_r, dc_r})
      2'b11: begin
        if (job_r.last_col) begin
          has_next = 1'b1; dc_nxt = 1'b0;
        end else if (job_r.last_row) begin
          has_next = 1'b1; dr_nxt = 1'b0;
        end
      end
      2'b10: begin
        if (job_r.last_row) begin
          has_next = 1'b1; dr_nxt = 1'b0; dc_nxt = 1'b1;
        end
      end
      2'b01: begin
        if (job_r.last_col) begin
          has_next = 1'b1; dc_nxt = 1'b0;
        end
      end
      default: has_next = 1'b0;
    endcase
  end

  assign rem_sh = {rem_r[csmg_pkg::REM_W-3:0], rad_r[csmg_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_mag   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: if (job_valid) state_r <= ST_GRAD;
        ST_GRAD: state_r <= ST_SQ;
        ST_SQ:   state_r <= ST_SEL;
        ST_SEL:  state_r <= ST_SQRT;
        ST_SQRT: if (cnt_r == 4'(csmg_pkg::MAG_W - 1)) state_r <= ST_OUT;
        ST_OUT:  if (out_ready) state_r <= has_next ? ST_GRAD : ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_r <= job;
          dr_r  <= 1'b1;
          dc_r  <= 1'b1;
        end
      end
      ST_GRAD: begin
        gx_r    <= gx_c;
        gy_r    <= gy_c;
        out_row <= rr;
        out_col <= cc;
      end
      ST_SQ: begin
        for (int k = 0; k < 3; k++)
          msq_r[k] <= sqx[k][csmg_pkg::MSQ_W-1:0] + sqy[k][csmg_pkg::MSQ_W-1:0];
      end
      ST_SEL: begin
        out_channel <= best;
        out_gx      <= gx_r[best];
        out_gy      <= gy_r[best];
        out_msq     <= msq_r[best];
        rad_r       <= csmg_pkg::RAD_W'({msq_r[best], (2*csmg_pkg::FRAC_BITS)'(0)});
        rem_r       <= '0;
        root_r      <= '0;
        cnt_r       <= '0;
      end
      ST_SQRT: begin
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[csmg_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[csmg_pkg::MAG_W-2:0], 1'b0};
        end
        if (cnt_r == 4'(csmg_pkg::MAG_W - 1)) out_last <= !has_next;
      end
      ST_OUT: begin
        if (out_ready && has_next) begin
          dr_r <= dr_nxt;
          dc_r <= dc_nxt;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (cnt_r < 4'(csmg_pkg::MAG_W))) else $error("root overran");
  a_out_from_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_SQRT)) else $error("result skipped root");
  a_msq_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_msq ==
      {{(csmg_pkg::MSQ_W-csmg_pkg::GRAD_W){out_gx[csmg_pkg::GRAD_W-1]}}, out_gx} *
      {{(csmg_pkg::MSQ_W-csmg_pkg::GRAD_W){out_gx[csmg_pkg::GRAD_W-1]}}, out_gx} +
      {{(csmg_pkg::MSQ_W-csmg_pkg::GRAD_W){out_gy[csmg_pkg::GRAD_W-1]}}, out_gy} *
      {{(csmg_pkg::MSQ_W-csmg_pkg::GRAD_W){out_gy[csmg_pkg::GRAD_W-1]}}, out_gy}))
    else $error("squared magnitude mismatch");
`endif

endmodule

/* sv/color_sobel_max_channel_gradient_top.sv */
// ----------------------------------------------------------------------------
// color_sobel_max_channel_gradient_top
// BGR raster in, per-pixel strongest-channel Sobel gradient out.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata {red, green, blue}
//  out_    | out | tdata {mag_fixed, mag_squared, grad_y, grad_x, row, col},
//          |     | tuser channel, tlast last
//  cfg_    | in  | index 0 image_width, 1 image_height
//
// Intake takes one pixel per clock while the two-entry job queue has room.
// The gradient engine loads a job while idle, then takes each result through
// three setup stages (GRAD, SQ, SEL), a 15-step square root and an output
// state, and takes the next job only from idle. Output stalls hold the engine.
// Reset (rst_n, synchronous) clears counters, window and queue; sizes go to
// 640 x 480. Line stores have no reset.
// ----------------------------------------------------------------------------
module color_sobel_max_channel_gradient_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // col, row, grad_x, grad_y, mag_squared, mag_fixed
  output logic [1:0]  out_tuser,  // channel
  output logic        out_tlast
);

  logic           job_valid, job_ready;
  csmg_pkg::job_t job;
  logic           q_valid, q_ready;
  csmg_pkg::job_t q_data;

  logic [csmg_pkg::COL_W-1:0]      o_col;
  logic [csmg_pkg::ROW_W-1:0]      o_row;
  logic signed [csmg_pkg::GRAD_W-1:0] o_gx, o_gy;
  logic [csmg_pkg::MSQ_W-1:0]      o_msq;
  logic [csmg_pkg::MAG_W-1:0]      o_mag;

  csmg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (in_tdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  csmg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  csmg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job         (q_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_col     (o_col),
    .out_row     (o_row),
    .out_gx      (o_gx),
    .out_gy      (o_gy),
    .out_msq     (o_msq),
    .out_mag     (o_mag),
    .out_channel (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'd0, o_mag, o_msq, o_gy, o_gx, o_row, o_col};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color Sobel max-channel gradient block. A
// clocked driver streams BGR pixels from a queue, a scoreboard model predicts
// every gradient result (position, winning channel, gx/gy, squared and fixed
// magnitude, last flag), and a clocked monitor compares each output transfer.
// Covers reg extremes (clamped sizes), mid-frame restart, idling mixes and a
// long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [10:0]        col;
    logic [11:0]        row;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [20:0]        msq;
    logic [14:0]        mag;
    logic [1:0]         chan;
    logic               last;
  } grad_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [12:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  color_sobel_max_channel_gradient_top dut (.*);

  // scoreboard model state
  logic [23:0] row_older [csmg_pkg::MAX_WIDTH];
  logic [23:0] row_newer [csmg_pkg::MAX_WIDTH];
  logic [23:0] win [3][3];
  int          pos_col, pos_row;
  logic [11:0] size_w_reg;
  logic [12:0] size_h_reg;

  logic [23:0] pixel_q[$];
  grad_res_t   grad_q[$];
  int          err_cnt;
  int          send_idle_pct, recv_stall_pct;
  int          hold_kick, hold_seen, hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int reflect(int i, int n);
    if (i < 0) i = -i;
    if (i >= n) i = 2 * n - 2 - i;
    return i;
  endfunction

  function automatic int win_slot(int i, int newest);
    int s;
    s = i - newest + 2;
    return (s < 0 || s > 2) ? 1 : s;
  endfunction

  function automatic logic [14:0] sqrt_fixed(logic [31:0] v);
    logic [31:0] res, t;
    res = 0;
    for (int b = 15; b >= 0; b--) begin
      t = res | (32'd1 << b);
      if (t * t <= v) res = t;
    end
    return res[14:0];
  endfunction

  function automatic grad_res_t pixel_gradient(int rr, int cc, int r, int c, int h, int w);
    grad_res_t g;
    int rs[3], cs[3];
    int p[3][3];
    int gx, gy, msq, best_msq;
    for (int d = 0; d < 3; d++) begin
      rs[d] = win_slot(reflect(rr + d - 1, h), r);
      cs[d] = win_slot(reflect(cc + d - 1, w), c);
    end
    best_msq = 0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] = int'(win[rs[i]][cs[j]][8*k +: 8]);
      gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
      gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
      msq = gx * gx + gy * gy;
      // strict compare keeps the lower channel on ties
      if (k == 0 || msq > best_msq) begin
        best_msq = msq;
        g.gx = gx[10:0];
        g.gy = gy[10:0];
        g.chan = (k == 0) ? csmg_pkg::CH_BLUE :
                 (k == 1) ? csmg_pkg::CH_GREEN : csmg_pkg::CH_RED;
      end
    end
    g.col = cc[10:0];
    g.row = rr[11:0];
    g.msq = best_msq[20:0];
    g.mag = sqrt_fixed(best_msq << (2 * csmg_pkg::FRAC_BITS));
    g.last = 1'b0;
    return g;
  endfunction

  function automatic void predict_pixel(logic [23:0] pix);
    int w, h, r, c;
    grad_res_t res[$];
    w = int'(size_w_reg);
    h = int'(size_h_reg);
    if (w < 2) w = 2;
    if (w > csmg_pkg::MAX_WIDTH) w = csmg_pkg::MAX_WIDTH;
    if (h < 2) h = 2;
    if (h > csmg_pkg::MAX_HEIGHT) h = csmg_pkg::MAX_HEIGHT;
    if (pos_col >= w || pos_row >= h) begin
      pos_col = 0;
      pos_row = 0;
    end
    r = pos_row;
    c = pos_col;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_older[c];
    win[1][2] = row_newer[c];
    win[2][2] = pix;
    row_older[c] = row_newer[c];
    row_newer[c] = pix;
    if (r >= 1 && c >= 1) begin
      res.insert(res.size(), pixel_gradient(r - 1, c - 1, r, c, h, w));
      if (c == w - 1) res.insert(res.size(), pixel_gradient(r - 1, c, r, c, h, w));
      if (r == h - 1) begin
        res.insert(res.size(), pixel_gradient(r, c - 1, r, c, h, w));
        if (c == w - 1) res.insert(res.size(), pixel_gradient(r, c, r, c, h, w));
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) grad_q.insert(grad_q.size(), res[i]);
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_pixel(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pixel_q[0];
          pixel_q.delete(0);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 800;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    grad_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (grad_q.size() == 0) begin
          $error("unexpected result transfer: %h", out_tdata);
          err_cnt++;
        end else begin
          e = grad_q[0];
          grad_q.delete(0);
          if (out_tdata[10:0] !== e.col) begin
            $error("col exp %0d got %0d", e.col, out_tdata[10:0]); err_cnt++;
          end
          if (out_tdata[22:11] !== e.row) begin
            $error("row exp %0d got %0d", e.row, out_tdata[22:11]); err_cnt++;
          end
          if (out_tdata[33:23] !== e.gx) begin
            $error("grad_x exp %0d got %0d", e.gx, $signed(out_tdata[33:23])); err_cnt++;
          end
          if (out_tdata[44:34] !== e.gy) begin
            $error("grad_y exp %0d got %0d", e.gy, $signed(out_tdata[44:34])); err_cnt++;
          end
          if (out_tdata[65:45] !== e.msq) begin
            $error("mag_squared exp %0d got %0d", e.msq, out_tdata[65:45]); err_cnt++;
          end
          if (out_tdata[80:66] !== e.mag) begin
            $error("mag_fixed exp %0d got %0d", e.mag, out_tdata[80:66]); err_cnt++;
          end
          if (out_tuser !== e.chan) begin
            $error("channel exp %0d got %0d", e.chan, out_tuser); err_cnt++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); err_cnt++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_tvalid || grad_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == csmg_pkg::REG_WIDTH) size_w_reg = val[11:0];
    else size_h_reg = val;
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [23:0] rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample()};
  endfunction

  task automatic queue_random(int n);
    repeat (n) pixel_q.insert(pixel_q.size(), rand_pixel());
  endtask

  initial begin
    int w, h, fed;
    logic [7:0] a;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = csmg_pkg::REG_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_kick = 0;
    hold_seen = 0;
    hold_left = 0;
    for (int i = 0; i < csmg_pkg::MAX_WIDTH; i++) begin
      row_older[i] = '0;
      row_newer[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    pos_col = 0;
    pos_row = 0;
    size_w_reg = 12'd640;
    size_h_reg = 13'd480;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 5x5 frame: full-swing checker, then single-channel and tie rows
    write_reg(csmg_pkg::REG_WIDTH, 13'd5);
    write_reg(csmg_pkg::REG_HEIGHT, 13'd5);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) begin
        a = ((r + c) % 2) ? 8'd255 : 8'd0;
        case (r)
          0, 1: pixel_q.insert(pixel_q.size(), {a, a, a});      // all equal: blue wins
          2:    pixel_q.insert(pixel_q.size(), {8'd0, a, 8'd0}); // green only
          3:    pixel_q.insert(pixel_q.size(), {a, 8'd0, 8'd0}); // red only
          default: pixel_q.insert(pixel_q.size(), {a, a, 8'd0}); // green/red tie
        endcase
      end
    wait_drained();

    // stop mid-frame, then shrink height under the row counter: frame restarts
    write_reg(csmg_pkg::REG_WIDTH, 13'd6);
    queue_random(20);
    wait_drained();
    write_reg(csmg_pkg::REG_HEIGHT, 13'd3);
    queue_random(18);
    wait_drained();
    // shrink width mid-frame past the column counter
    queue_random(9);
    wait_drained();
    write_reg(csmg_pkg::REG_WIDTH, 13'd2);
    queue_random(6);
    wait_drained();

    // below-range sizes clamp to 2x2
    write_reg(csmg_pkg::REG_WIDTH, 13'd0);
    write_reg(csmg_pkg::REG_HEIGHT, 13'd1);
    queue_random(20);
    wait_drained();

    // width above range (clamped): start of a first row
    write_reg(csmg_pkg::REG_WIDTH, 13'd4095);
    write_reg(csmg_pkg::REG_HEIGHT, 13'd2);
    queue_random(30);
    wait_drained();

    // height above range (clamped), two columns, first rows
    write_reg(csmg_pkg::REG_WIDTH, 13'd2);
    write_reg(csmg_pkg::REG_HEIGHT, 13'd8191);
    queue_random(24);
    wait_drained();

    // random small frames under each idling mix
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 3) ? 23 : 69) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 23 : 69) : 0;
      fed = 0;
      while (fed < 48) begin
        w = $urandom_range(9, 2);
        h = $urandom_range(7, 2);
        write_reg(csmg_pkg::REG_WIDTH, w[12:0]);
        write_reg(csmg_pkg::REG_HEIGHT, h[12:0]);
        queue_random(w * h);
        fed += w * h;
        wait_drained();
      end
    end

    // output held off while pixels keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(csmg_pkg::REG_WIDTH, 13'd8);
    write_reg(csmg_pkg::REG_HEIGHT, 13'd7);
    queue_random(56);
    @(negedge clk);
    hold_kick = 1;
    wait_drained();

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/csmg_pkg.sv
sv/csmg_ram.sv
sv/csmg_front.sv
sv/csmg_queue.sv
sv/csmg_back.sv
sv/color_sobel_max_channel_gradient_top.sv
verif/tb.sv
